FILE: rtl/pcf_pkg.sv
// shared types, constants and crc helpers for the png chunk framer
package pcf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHUNK_TYPE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DATA_LENGTH = 2'd1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       chunk_end;
      logic       error;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_ERROR = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       close;
   } cmd_type;

   function automatic logic [31:0] crc_fold8(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // sel 0 picks the high byte
   function automatic logic [7:0] byte_select(input logic [31:0] word, input logic [1:0] sel);
      logic [31:0] shifted;
      shifted = word >> {~sel, 3'b000};
      return shifted[7:0];
   endfunction

endpackage

FILE: rtl/pcf_front.sv
// front end: accepts requests, tracks the open chunk and queues commands
module pcf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pcf_pkg::req_payload_type req_payload,
   input  logic [30:0]              data_length,
   output logic                     push_valid,
   input  logic                     push_ready,
   output pcf_pkg::cmd_type         push_cmd
);

   logic [30:0] bytes_left_ff, bytes_left_in;
   logic        open_ff, open_in;
   logic        accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      bytes_left_in      = bytes_left_ff;
      open_in            = open_ff;
      push_cmd.data_byte = req_payload.data_byte;
      push_cmd.close     = 1'b0;
      push_cmd.op        = pcf_pkg::OP_ERROR;
      if (req_payload.kind == pcf_pkg::KIND_START) begin
         push_cmd.op    = pcf_pkg::OP_START;
         push_cmd.close = (data_length == 31'd0);
         bytes_left_in  = data_length;
         open_in        = (data_length != 31'd0);
      end else if (open_ff) begin
         push_cmd.op    = pcf_pkg::OP_DATA;
         push_cmd.close = (bytes_left_ff == 31'd1);
         bytes_left_in  = bytes_left_ff - 31'd1;
         open_in        = (bytes_left_ff != 31'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         open_ff       <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         open_ff       <= open_in;
      end
   end

endmodule

FILE: rtl/pcf_queue.sv
// short command queue between front and back
module pcf_queue #(
   parameter int DEPTH = pcf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pcf_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pcf_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcf_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/pcf_back.sv
// back end: serializes commands into bytes and runs the crc
module pcf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  pcf_pkg::cmd_type         pop_cmd,
   input  logic [31:0]              chunk_type,
   input  logic [30:0]              data_length,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pcf_pkg::rsp_payload_type rsp_payload
);

   localparam logic [3:0] PH_TYPE_FIRST  = 4'd4;
   localparam logic [3:0] PH_TYPE_LAST   = 4'd7;
   localparam logic [3:0] PH_START_CRC   = 4'd11;
   localparam logic [3:0] PH_DATA_CRC    = 4'd4;

   pcf_pkg::cmd_type         held_ff;
   logic                     act_ff, act_in;
   logic [3:0]               phase_ff, phase_in;
   logic [31:0]              crc_ff, crc_in;
   logic                     rsp_valid_ff;
   pcf_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   pcf_pkg::cmd_type cur;
   logic             cur_valid;
   logic [3:0]       phase;
   logic [3:0]       crc_phase;
   logic             load_en;
   logic             step;
   logic             final_byte;

   assign cur       = act_ff ? held_ff : pop_cmd;
   assign cur_valid = act_ff || pop_valid;
   assign phase     = act_ff ? phase_ff : 4'd0;
   assign crc_phase = phase - 4'd1;
   assign load_en   = !rsp_valid_ff || rsp_ready;
   assign step      = load_en && cur_valid;
   assign pop_ready = load_en && !act_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      rsp_payload_in = '0;
      crc_in         = crc_ff;
      final_byte     = 1'b1;
      case (cur.op)
         pcf_pkg::OP_START: begin
            final_byte = cur.close ? (phase == PH_START_CRC) : (phase == PH_TYPE_LAST);
            if (phase < PH_TYPE_FIRST) begin
               rsp_payload_in.out_byte = pcf_pkg::byte_select({1'b0, data_length}, phase[1:0]);
               if (phase == 4'd0) begin
                  crc_in = pcf_pkg::CRC_ONES;
               end
            end else if (phase <= PH_TYPE_LAST) begin
               rsp_payload_in.out_byte = pcf_pkg::byte_select(chunk_type, phase[1:0]);
               crc_in = pcf_pkg::crc_fold8(crc_ff, rsp_payload_in.out_byte);
            end else begin
               rsp_payload_in.out_byte  = pcf_pkg::byte_select(~crc_ff, phase[1:0]);
               rsp_payload_in.chunk_end = (phase == PH_START_CRC);
            end
         end
         pcf_pkg::OP_DATA: begin
            if (phase == 4'd0) begin
               rsp_payload_in.out_byte = cur.data_byte;
               crc_in     = pcf_pkg::crc_fold8(crc_ff, cur.data_byte);
               final_byte = !cur.close;
            end else begin
               rsp_payload_in.out_byte  = pcf_pkg::byte_select(~crc_ff, crc_phase[1:0]);
               rsp_payload_in.chunk_end = (phase == PH_DATA_CRC);
               final_byte               = (phase == PH_DATA_CRC);
            end
         end
         pcf_pkg::OP_ERROR: begin
            rsp_payload_in.error = 1'b1;
         end
         default: begin
            final_byte = 1'b1;
         end
      endcase
      rsp_payload_in.last = final_byte;
   end

   always_comb begin
      act_in   = act_ff;
      phase_in = phase_ff;
      if (step) begin
         act_in   = !final_byte;
         phase_in = phase + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         phase_ff     <= '0;
         crc_ff       <= pcf_pkg::CRC_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         phase_ff <= phase_in;
         if (step) begin
            crc_ff <= crc_in;
         end
         if (load_en) begin
            rsp_valid_ff <= cur_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_payload_ff <= rsp_payload_in;
         if (!act_ff) begin
            held_ff <= pop_cmd;
         end
      end
   end

endmodule

FILE: rtl/png_chunk_crc32_framer_top.sv
// top level of the png chunk framer with crc-32
// a short command queue lets requests flow in while the back end drains longer commands
// throughput: one response byte per cycle from the single output register while rsp_ready
// is high; a data request emits one byte (five when it closes the chunk), a start emits
// eight (twelve at zero length); requests pass the queue, then the output register
// reset is synchronous: no chunk open, crc all ones, config registers zero, queue empty
module png_chunk_crc32_framer_top #(
   parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pcf_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pcf_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                           csr_wdata
);

   logic [31:0]      chunk_type_ff;
   logic [30:0]      data_length_ff;
   logic             push_valid, push_ready;
   pcf_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   pcf_pkg::cmd_type pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_type_ff  <= '0;
         data_length_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == pcf_pkg::REG_CHUNK_TYPE) begin
            chunk_type_ff <= csr_wdata;
         end else if (csr_index == pcf_pkg::REG_DATA_LENGTH) begin
            data_length_ff <= csr_wdata[30:0];
         end
      end
   end

   pcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .data_length (data_length_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .chunk_type  (chunk_type_ff),
      .data_length (data_length_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the png chunk framer: directed table, then random chunk traffic
module testbench;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 430;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PRESSURE_CHUNK = 6;
   localparam int PLAN_ROWS = 32;
   localparam logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] REG_CHUNK_TYPE = pcf_pkg::REG_CHUNK_TYPE;
   localparam logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] REG_DATA_LENGTH = pcf_pkg::REG_DATA_LENGTH;
   localparam logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;
   localparam logic KIND_START = pcf_pkg::KIND_START;
   localparam logic KIND_DATA = pcf_pkg::KIND_DATA;

   typedef enum logic {ACT_ITEM, ACT_CSR} plan_act_type;

   typedef struct packed {
      plan_act_type                        act;
      logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [31:0]                         wdata;
      logic                                kind;
      logic [7:0]                          data;
      logic                                typed;
      logic [3:0]                          count;
      logic [95:0]                         bytes;
      logic                                err;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   pcf_pkg::req_payload_type req_payload = '0;
   plan_row_type req_row = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_ready;
   logic rsp_valid;
   logic csr_ready;
   pcf_pkg::rsp_payload_type rsp_payload;

   logic calm = 1'b0;
   logic hold_go = 1'b0;
   logic held = 1'b0;
   int hold_left = 0;

   logic [31:0] crc_state = pcf_pkg::CRC_ONES;
   logic [30:0] bytes_to_go = '0;
   logic chunk_live = 1'b0;
   logic [31:0] cfg_type = '0;
   logic [30:0] cfg_length = '0;
   pcf_pkg::rsp_payload_type chunk_stream_q [$];
   pcf_pkg::rsp_payload_type want;
   logic moved;
   int n_before;

   int quiet_cycles = 0;
   int mismatches = 0;
   int requests_seen = 0;
   int rsp_total = 0;
   int closed_chunks = 0;
   int stray_errors = 0;
   int csr_writes = 0;
   int directed_items = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'ha5, 1'b1, 4'd1, 96'h0, 1'b1},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00,
        1'b1, 4'd12, 96'h00000000_00000000_2144df1c, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h00, 1'b1, 4'd1, 96'h0, 1'b1},
      '{ACT_CSR, REG_CHUNK_TYPE, 32'hffffffff, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_DATA_LENGTH, 32'hffffffff, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'hff,
        1'b1, 4'd8, 96'h7fffffff_ffffffff_00000000, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'hff, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_DATA_LENGTH, 32'h0, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      // abandons the open chunk
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00,
        1'b1, 4'd12, 96'h00000000_ffffffff_ffffffff, 1'b0},
      '{ACT_CSR, REG_CHUNK_TYPE, 32'h49444154, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_DATA_LENGTH, 32'h3, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_SPARE_2, 32'hdeadbeef, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_SPARE_3, 32'hffffffff, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h5a, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h80, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h7f, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h55, 1'b1, 4'd1, 96'h0, 1'b1},
      '{ACT_CSR, REG_DATA_LENGTH, 32'h2, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h11, 1'b0, 4'd0, 96'h0, 1'b0},
      // writes while a chunk is open only apply to the next start
      '{ACT_CSR, REG_DATA_LENGTH, 32'h5, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h22, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h01, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'h02, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_CHUNK_TYPE, 32'h49454e44, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_CSR, REG_DATA_LENGTH, 32'h0, KIND_START, 8'h00, 1'b0, 4'd0, 96'h0, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_START, 8'h00,
        1'b1, 4'd12, 96'h00000000_49454e44_ae426082, 1'b0},
      '{ACT_ITEM, REG_CHUNK_TYPE, 32'h0, KIND_DATA, 8'hff, 1'b1, 4'd1, 96'h0, 1'b1}
   };

   png_chunk_crc32_framer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (pcf_pkg::CRC_POLY & {32{c[0] ^ b[i]}});
      end
      return c;
   endfunction

   task automatic emit_byte(input logic [7:0] b, input logic fin, input logic cend,
                            input logic err);
      chunk_stream_q.push_back(pcf_pkg::rsp_payload_type'{out_byte: b, last: fin,
                                                          chunk_end: cend, error: err});
   endtask

   task automatic emit_crc();
      logic [31:0] sum;
      sum = ~crc_state;
      for (int i = 3; i >= 0; i--) begin
         emit_byte(sum[8*i +: 8], i == 0, i == 0, 1'b0);
      end
      chunk_live = 1'b0;
      crc_state = pcf_pkg::CRC_ONES;
   endtask

   task automatic frame_request(input pcf_pkg::req_payload_type req);
      logic [31:0] word;
      if (req.kind == KIND_START) begin
         word = {1'b0, cfg_length};
         for (int i = 3; i >= 0; i--) begin
            emit_byte(word[8*i +: 8], 1'b0, 1'b0, 1'b0);
         end
         crc_state = pcf_pkg::CRC_ONES;
         for (int i = 3; i >= 0; i--) begin
            emit_byte(cfg_type[8*i +: 8], i == 0 && cfg_length != 0, 1'b0, 1'b0);
            crc_state = crc_update(crc_state, cfg_type[8*i +: 8]);
         end
         bytes_to_go = cfg_length;
         chunk_live = 1'b1;
         if (cfg_length == 0) begin
            emit_crc();
         end
      end else if (!chunk_live) begin
         emit_byte(8'h00, 1'b1, 1'b0, 1'b1);
      end else begin
         bytes_to_go = bytes_to_go - 1'b1;
         emit_byte(req.data_byte, bytes_to_go != 0, 1'b0, 1'b0);
         crc_state = crc_update(crc_state, req.data_byte);
         if (bytes_to_go == 0) begin
            emit_crc();
         end
      end
   endtask

   task automatic report_mismatch(input string field, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      if (mismatches < 50) begin
         $display("mismatch on response %0d: %s got %h, expected %h",
                  rsp_total, field, got, exp_val);
      end
      mismatches++;
   endtask

   // monitor: config shadow, prediction on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      if (reset) begin
         crc_state = pcf_pkg::CRC_ONES;
         bytes_to_go = '0;
         chunk_live = 1'b0;
         cfg_type = '0;
         cfg_length = '0;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               REG_CHUNK_TYPE: cfg_type = csr_wdata;
               REG_DATA_LENGTH: cfg_length = csr_wdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            requests_seen++;
            n_before = chunk_stream_q.size();
            frame_request(req_payload);
            if (req_row.typed) begin
               while (chunk_stream_q.size() > n_before) begin
                  void'(chunk_stream_q.pop_back());
               end
               for (int k = 0; k < req_row.count; k++) begin
                  chunk_stream_q.push_back(pcf_pkg::rsp_payload_type'{
                     out_byte: req_row.bytes[95 - 8*k -: 8],
                     last: k == req_row.count - 1,
                     chunk_end: k == 11,
                     error: req_row.err});
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            rsp_total++;
            if (chunk_stream_q.size() == 0) begin
               report_mismatch("unexpected response, out_byte", rsp_payload.out_byte, 8'h00);
            end else begin
               want = chunk_stream_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_payload.out_byte, want.out_byte);
               if (rsp_payload.last !== want.last)
                  report_mismatch("last", 8'(rsp_payload.last), 8'(want.last));
               if (rsp_payload.chunk_end !== want.chunk_end)
                  report_mismatch("chunk_end", 8'(rsp_payload.chunk_end), 8'(want.chunk_end));
               if (rsp_payload.error !== want.error)
                  report_mismatch("error", 8'(rsp_payload.error), 8'(want.error));
               if (want.chunk_end) closed_chunks++;
               if (want.error) stray_errors++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // response side: random stalls, one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !held) begin
         held <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 38);
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("timeout: no handshake for %0d cycles, %0d response bytes outstanding",
               QUIET_LIMIT, chunk_stream_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_request(input plan_row_type row);
      csr_valid <= 1'b0;
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= pcf_pkg::req_payload_type'{kind: row.kind, data_byte: row.data};
      req_row <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pcf_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [31:0] value);
      req_valid <= 1'b0;
      while (!calm && $urandom_range(99) < 38) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (chunk_stream_q.size() != 0);
   endtask

   task automatic send_random(input logic kind);
      plan_row_type row;
      row = '0;
      row.act = ACT_ITEM;
      row.kind = kind;
      row.data = 8'($urandom_range(255));
      send_request(row);
   endtask

   initial begin
      int random_items;
      int chunk_no;
      int body;
      int len_pick;
      logic [31:0] len_word;
      logic [30:0] cur_length;
      random_items = 0;
      chunk_no = 0;
      cur_length = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].act == ACT_CSR) begin
            wait_drained();
            write_reg(plan[i].index, plan[i].wdata);
         end else begin
            send_request(plan[i]);
            directed_items++;
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         if (chunk_no == 20) calm <= 1'b1;
         else if (chunk_no == 32) calm <= 1'b0;
         if (chunk_no == PRESSURE_CHUNK || $urandom_range(99) < 35) begin
            wait_drained();
            if ($urandom_range(7) == 0)
               write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
            write_reg(REG_CHUNK_TYPE, $urandom);
            len_pick = $urandom_range(99);
            if (chunk_no == PRESSURE_CHUNK) begin
               len_word = 32'd40;
            end else if (len_pick < 80) begin
               len_word = $urandom_range(12);
               len_word[31] = 1'($urandom_range(1));
            end else if (len_pick < 92) begin
               len_word = $urandom_range(40, 13);
            end else begin
               len_word = $urandom;
            end
            write_reg(REG_DATA_LENGTH, len_word);
            cur_length = len_word[30:0];
            if (chunk_no == PRESSURE_CHUNK) hold_go <= 1'b1;
         end
         // long lengths are never finished, the next start abandons them
         if (cur_length > 40) body = $urandom_range(6);
         else if (chunk_no != PRESSURE_CHUNK && cur_length != 0 && $urandom_range(99) < 15)
            body = $urandom_range(cur_length - 1);
         else body = cur_length;
         send_random(KIND_START);
         random_items++;
         repeat (body) begin
            send_random(KIND_DATA);
            random_items++;
         end
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(2, 1)) begin
               send_random(KIND_DATA);
               random_items++;
            end
         end
         chunk_no++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("run covered %0d requests (%0d directed), %0d chunks started at random",
               requests_seen, directed_items, chunk_no);
      $display("%0d response bytes, %0d chunks closed, %0d stray bytes, %0d csr writes",
               rsp_total, closed_chunks, stray_errors, csr_writes);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
